// ===== design/kaf1d_pkg.sv =====
// Package for the one-dimensional Kalman angle filter.
// Holds the sequencer state type, reset constants and a saturation helper.
// Has no dependencies; imported by kalman_angle_filter_1d.
`timescale 1ns / 1ps

package kaf1d_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [15:0] TIME_STEP_RESET = 16'd262;
	localparam logic [31:0] PROC_VAR_RESET  = 32'd17;
	localparam logic [31:0] MEAS_VAR_RESET  = 32'd589824;
	localparam logic [31:0] VAR_RESET       = 32'(64'd4 << FRAC_BITS);

	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_PROC_VAR  = 2'd1;
	localparam logic [1:0] REG_MEAS_VAR  = 2'd2;

	localparam logic [4:0] LAST_STEP = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_PRED,
		ST_INNOV,
		ST_MUL,
		ST_FIN
	} state_t;

	// Clamp a 34-bit two's complement value to the signed 32-bit range.
	function automatic logic [31:0] sat34(input logic [33:0] x);
		logic [31:0] r;
		if (!x[33] && (x[32:31] != 2'b00)) begin
			r = 32'h7FFF_FFFF;
		end else if (x[33] && (x[32:31] != 2'b11)) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ===== design/kalman_angle_filter_1d.sv =====
// Top level of the one-dimensional Kalman angle filter (gyro rate fused with angle).
// Bit-serial divider for the gain and bit-serial multipliers for the products.
// Depends on kaf1d_pkg.
`timescale 1ns / 1ps

// Usage
// Each input transaction on the s_axis side carries a gyro rate and a measured
// angle. The block predicts the angle from the rate, computes the Kalman gain,
// corrects the angle and the variance, stores both as the new state and returns
// them as one transaction on the m_axis side.
// Configuration registers (time step, process variance step, measurement
// variance) are written through cfg_wr_en / cfg_index / cfg_data. A write takes
// effect at the clock edge; indexes beyond the list are ignored. Registers are
// meant to be changed only while no transaction is in flight.
// The result is registered in the final step. The gain takes a 17-step
// restoring divider, one quotient bit per cycle, and the correction takes a
// 16-step shift-and-add multiplier plus a rounding step; these two serial
// units take most of the processing time. One item is processed at a time, so
// a new item is accepted only once the last result has left the final step.
// The output register decouples the sides: a finished result waits there while
// the next item is accepted and processed. If the receiver still holds off when
// the following result is done, the sequencer waits in its final step.
// Reset clears the estimate to zero, the variance to four and the registers to
// their defaults.
module kalman_angle_filter_1d
	import kaf1d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] rate_in, [63:32] angle_meas

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [31:0] angle_out, [63:32] uncertainty_out
);

	// Configuration registers.
	logic [15:0] time_step_q;
	logic [31:0] proc_var_q;
	logic [31:0] meas_var_q;

	// Filter state.
	logic [31:0] angle_q;
	logic [31:0] var_q;

	// Sequencer.
	state_t      state_q, state_d;
	logic [4:0]  cnt_q;

	// Working registers of one item.
	logic [31:0] rate_q;
	logic [31:0] meas_q;
	logic [31:0] unc_q;      // predicted variance
	logic [32:0] den_q;      // unc + meas_var
	logic [33:0] rem_q;      // divider remainder
	logic [16:0] quot_q;     // divider quotient, one bit above the gain range
	logic [15:0] ts_q;       // time step, consumed MSB first
	logic [47:0] acc1_q;     // time_step * rate, then rounded
	logic [31:0] pred_q;     // predicted angle
	logic [15:0] gain_q;     // Q0.16, consumed MSB first during the correction
	logic [32:0] innov_q;    // measurement minus prediction
	logic [48:0] acc2_q;     // gain * innovation, then rounded
	logic [47:0] acc3_q;     // unc * gain, then unc * (1 - gain) rounded

	logic        out_valid_q;
	logic [63:0] out_data_q;

	logic        in_take;
	logic        fin_load;

	logic [32:0] unc_sum;
	logic [34:0] div_diff;
	logic        div_ge;
	logic [33:0] pred_sum;
	logic [33:0] angle_sum;

	// Control outputs of the sequencer.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		fin_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
	end

	assign in_take = s_axis_tvalid && s_axis_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_take) state_d = ST_PREP;
			ST_PREP:  state_d = ST_DIV;
			ST_DIV:   if (cnt_q == LAST_STEP) state_d = ST_PRED;
			ST_PRED:  state_d = ST_INNOV;
			ST_INNOV: state_d = ST_MUL;
			ST_MUL:   if (cnt_q == LAST_STEP) state_d = ST_FIN;
			ST_FIN:   if (fin_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Datapath arithmetic.
	assign unc_sum   = {1'b0, var_q} + {1'b0, proc_var_q};
	assign div_diff  = {1'b0, rem_q} - {2'b00, den_q};
	assign div_ge    = !div_diff[34];
	assign pred_sum  = {{2{angle_q[31]}}, angle_q} + {{2{acc1_q[47]}}, acc1_q[47:16]};
	assign angle_sum = {{2{pred_q[31]}}, pred_q} + {acc2_q[48], acc2_q[48:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RESET;
			proc_var_q  <= PROC_VAR_RESET;
			meas_var_q  <= MEAS_VAR_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_data[15:0];
				REG_PROC_VAR:  proc_var_q  <= cfg_data;
				REG_MEAS_VAR:  meas_var_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			angle_q     <= '0;
			var_q       <= VAR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP || state_q == ST_INNOV) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV || state_q == ST_MUL) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (fin_load) begin
				angle_q     <= sat34(angle_sum);
				var_q       <= acc3_q[47:16];
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					rate_q <= s_axis_tdata[31:0];
					meas_q <= s_axis_tdata[63:32];
					unc_q  <= unc_sum[32] ? 32'hFFFF_FFFF : unc_sum[31:0];
					ts_q   <= time_step_q;
				end
			end
			ST_PREP: begin
				den_q  <= {1'b0, unc_q} + {1'b0, meas_var_q};
				rem_q  <= {2'b00, unc_q};
				quot_q <= '0;
				acc1_q <= '0;
			end
			ST_DIV: begin
				// One restoring-division step per cycle.
				quot_q <= {quot_q[15:0], div_ge};
				rem_q  <= {(div_ge ? div_diff[32:0] : rem_q[32:0]), 1'b0};
				if (cnt_q == LAST_STEP) begin
					acc1_q <= acc1_q + 48'd32768;
				end else begin
					acc1_q <= {acc1_q[46:0], 1'b0}
						+ (ts_q[15] ? {{16{rate_q[31]}}, rate_q} : 48'd0);
					ts_q   <= {ts_q[14:0], 1'b0};
				end
			end
			ST_PRED: begin
				pred_q <= sat34(pred_sum);
				if (den_q == '0) begin
					gain_q <= '0;
				end else if (quot_q[16]) begin
					gain_q <= 16'hFFFF;
				end else begin
					gain_q <= quot_q[15:0];
				end
			end
			ST_INNOV: begin
				innov_q <= {meas_q[31], meas_q} - {pred_q[31], pred_q};
				acc2_q  <= '0;
				acc3_q  <= '0;
			end
			ST_MUL: begin
				if (cnt_q == LAST_STEP) begin
					acc2_q <= acc2_q + 49'd32768;
					acc3_q <= {unc_q, 16'd0} - acc3_q + 48'd32768;
				end else begin
					acc2_q <= {acc2_q[47:0], 1'b0}
						+ (gain_q[15] ? {{16{innov_q[32]}}, innov_q} : 49'd0);
					acc3_q <= {acc3_q[46:0], 1'b0}
						+ (gain_q[15] ? {16'd0, unc_q} : 48'd0);
					gain_q <= {gain_q[14:0], 1'b0};
				end
			end
			ST_FIN: begin
				if (fin_load) begin
					out_data_q <= {acc3_q[47:16], sat34(angle_sum)};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A result only appears from the final step of the sequencer.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final step");

	// An accepted transaction always starts the setup step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_PREP))
		else $error("accepted transaction did not start processing");

	// The serial step counter never runs past the last step.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_MUL) |-> (cnt_q <= LAST_STEP))
		else $error("serial step counter out of range");

	// The correction never increases the predicted variance.
	a_var_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> (var_q <= $past(unc_q)))
		else $error("corrected variance above predicted variance");

endmodule
